@@ rtl/touch_sweep_gesture_detector_defines.svh @@
// -----------------------------------------------------------------------------
// touch_sweep_gesture_detector_defines.svh
// Assertion macros shared by the sweep gesture detector.
// -----------------------------------------------------------------------------
`ifndef TOUCH_SWEEP_GESTURE_DETECTOR_DEFINES_SVH
`define TOUCH_SWEEP_GESTURE_DETECTOR_DEFINES_SVH

// Same-cycle implication, reset masked.
`define TSGD_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("tsgd assertion failed");

// Next-cycle implication, reset masked.
`define TSGD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("tsgd assertion failed");

`endif

@@ rtl/tsgd_pkg.sv @@
// -----------------------------------------------------------------------------
// tsgd_pkg
// Types and constants of the touch sweep gesture detector.
// -----------------------------------------------------------------------------
package tsgd_pkg;

    // Coordinates are compared at 17 bits signed, wide enough for any
    // sign-extended 16-bit coordinate and for every threshold below.
    typedef logic signed [16:0] t_coord;

    // Event opcodes
    localparam logic [2:0] OP_X_POS     = 3'd0;
    localparam logic [2:0] OP_Y_POS     = 3'd1;
    localparam logic [2:0] OP_SLOT      = 3'd2;
    localparam logic [2:0] OP_TRACK_ID  = 3'd3;
    localparam logic [2:0] OP_PANEL_ON  = 3'd4;
    localparam logic [2:0] OP_PANEL_OFF = 3'd5;

    // Configuration register indexes
    localparam logic REG_WAKE_EN  = 1'b0;
    localparam logic REG_SLEEP_EN = 1'b1;

    // Tracking id meaning "finger released"
    localparam logic [15:0] TRACK_RELEASED = 16'hFFFF;

    // Panel geometry
    localparam t_coord Y_MAX   = 17'sd1280;
    localparam t_coord X_MAX   = 17'sd720;
    localparam t_coord Y_STRIP = Y_MAX - 17'sd100;
    localparam t_coord X_EDGE  = 17'sd160;
    localparam t_coord X_FAR   = X_MAX - X_EDGE;
    localparam t_coord XB0     = 17'sd430;
    localparam t_coord XB1     = XB0 - 17'sd300;
    localparam t_coord XB2     = XB0 - 17'sd70;
    localparam t_coord XB3     = XB0 + 17'sd60;
    localparam t_coord XB4     = X_MAX - 17'sd145;
    localparam t_coord XB5     = X_MAX - XB0;

    // Gesture progress handed to and from the sweep checker
    typedef struct packed {
        logic [1:0] fwd;
        logic [1:0] rev;
        logic       armed;
    } t_sweep_state;

    typedef struct packed {
        logic press;
        logic wake;
    } t_result;

endpackage

@@ rtl/tsgd_sweep_check.sv @@
// -----------------------------------------------------------------------------
// tsgd_sweep_check
// Checks one paired point against the forward and reverse sweep stages.
// -----------------------------------------------------------------------------
module tsgd_sweep_check (
    input  tsgd_pkg::t_coord       i_x,
    input  tsgd_pkg::t_coord       i_y,
    input  logic                   i_panel_off,
    input  tsgd_pkg::t_sweep_state i_state,
    output tsgd_pkg::t_sweep_state o_state,
    output logic                   o_hit
);

    logic fs0, fs1, ffin, rs0, rs1, rfin;
    logic f_b0, f_go, f_hit, armed_mid;
    logic r_b0, r_go, r_hit;

    always_comb begin
        if (i_panel_off) begin
            // wake: horizontal sweep either way
            fs0  = (i_x > 17'sd0) && (i_x < tsgd_pkg::XB1) && (i_y > 17'sd0);
            fs1  = (i_x > tsgd_pkg::XB1) && (i_x < tsgd_pkg::XB2) && (i_y > 17'sd0);
            ffin = (i_x > tsgd_pkg::XB2) && (i_y > 17'sd0) && (i_x > tsgd_pkg::X_FAR);
            rs0  = (i_x < tsgd_pkg::X_FAR) && (i_x > tsgd_pkg::XB2) && (i_y < tsgd_pkg::Y_MAX);
            rs1  = (i_x < tsgd_pkg::XB2) && (i_x > tsgd_pkg::XB1) && (i_y < tsgd_pkg::Y_MAX);
            rfin = (i_x < tsgd_pkg::XB1) && (i_x < tsgd_pkg::X_EDGE)
                && (i_y < tsgd_pkg::Y_MAX);
        end else begin
            // sleep: sweep along the bottom strip
            fs0  = (i_x < tsgd_pkg::X_FAR) && (i_x > tsgd_pkg::XB2)
                && (i_y > tsgd_pkg::Y_STRIP);
            fs1  = (i_x < tsgd_pkg::XB2) && (i_x > tsgd_pkg::XB1) && (i_y > tsgd_pkg::Y_STRIP);
            ffin = (i_x < tsgd_pkg::XB1) && (i_y > tsgd_pkg::Y_STRIP)
                && (i_x < tsgd_pkg::X_EDGE);
            rs0  = (i_x > tsgd_pkg::XB0) && (i_x < tsgd_pkg::XB3) && (i_y > tsgd_pkg::Y_STRIP);
            rs1  = (i_x > tsgd_pkg::XB3) && (i_x < tsgd_pkg::XB4) && (i_y > tsgd_pkg::Y_STRIP);
            rfin = (i_x > tsgd_pkg::XB4) && (i_y > tsgd_pkg::Y_STRIP) && (i_x > tsgd_pkg::XB5);
        end
    end

    // forward sweep goes first and may use up the arm
    assign f_b0      = i_state.fwd[0] | fs0;
    assign f_go      = f_b0 & (i_state.fwd[1] | fs1);
    assign f_hit     = f_go & ffin & i_state.armed;
    assign armed_mid = i_state.armed & ~f_hit;

    assign r_b0  = i_state.rev[0] | rs0;
    assign r_go  = r_b0 & (i_state.rev[1] | rs1);
    assign r_hit = r_go & rfin & armed_mid;

    assign o_state.fwd   = {i_state.fwd[1] | f_go, f_b0};
    assign o_state.rev   = {i_state.rev[1] | r_go, r_b0};
    assign o_state.armed = armed_mid & ~r_hit;
    assign o_hit         = f_hit | r_hit;

endmodule

@@ rtl/touch_sweep_gesture_detector.sv @@
// -----------------------------------------------------------------------------
// touch_sweep_gesture_detector
// Sweep-to-wake / sweep-to-sleep detector on a touch event stream.
// Input beat: opcode + event_value (i_valid / o_stall). Output beat:
// power_press + press_is_wake (o_valid / i_stall), exactly one per input beat.
// An accepted event's result is registered into the output register, or
// into the skid register, which takes one result while the output is
// stalled. One event per cycle is sustained while o_stall is low; the
// whole update is a single pass of compares between the state and result
// registers. o_stall rises only while the skid register is occupied.
// Reset (synchronous, active low) empties both registers, clears the stored
// point and stages, arms the detector, marks the panel on, and loads the
// enables with wake off and sleep on. Config writes are registered.
// -----------------------------------------------------------------------------
`include "touch_sweep_gesture_detector_defines.svh"

module touch_sweep_gesture_detector #(
    parameter int COORD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // event channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_opcode,
    input  logic signed [15:0] i_event_value,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_power_press,
    output logic               o_press_is_wake,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic               i_cfg_data
);

    // coordinate width actually stored (never more than the event field)
    localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;

    // configuration
    logic r_wake_en, r_sleep_en;

    // gesture state
    logic signed [CW-1:0]   r_touch_x, n_touch_x;
    logic signed [CW-1:0]   r_touch_y, n_touch_y;
    logic                   r_x_seen, n_x_seen;
    logic                   r_y_seen, n_y_seen;
    logic                   r_panel_off, n_panel_off;
    tsgd_pkg::t_sweep_state r_sweep, n_sweep;

    // output register and skid
    logic              r_out_valid, r_skid_valid;
    tsgd_pkg::t_result r_out, r_skid, w_res;

    logic                   w_in_beat, w_out_beat, w_enabled, w_lift, w_pair, w_hit;
    logic signed [CW-1:0]   w_coord;
    logic signed [CW-1:0]   w_pt_x;
    logic signed [CW-1:0]   w_pt_y;
    tsgd_pkg::t_sweep_state w_chk_state;

    assign w_in_beat  = i_valid & ~o_stall;
    assign w_out_beat = r_out_valid & ~i_stall;
    assign w_coord    = i_event_value[CW-1:0];
    assign w_enabled  = r_panel_off ? r_wake_en : r_sleep_en;
    assign w_lift     = (i_opcode == tsgd_pkg::OP_SLOT)
                     || ((i_opcode == tsgd_pkg::OP_TRACK_ID)
                         && (i_event_value == tsgd_pkg::TRACK_RELEASED));
    // a point is ready once both halves have arrived, counting this beat
    assign w_pair     = (r_x_seen || (i_opcode == tsgd_pkg::OP_X_POS))
                     && (r_y_seen || (i_opcode == tsgd_pkg::OP_Y_POS));
    // point as it stands after this beat
    assign w_pt_x     = (i_opcode == tsgd_pkg::OP_X_POS) ? w_coord : r_touch_x;
    assign w_pt_y     = (i_opcode == tsgd_pkg::OP_Y_POS) ? w_coord : r_touch_y;

    tsgd_sweep_check u_check (
        .i_x         (tsgd_pkg::t_coord'(w_pt_x)),
        .i_y         (tsgd_pkg::t_coord'(w_pt_y)),
        .i_panel_off (r_panel_off),
        .i_state     (r_sweep),
        .o_state     (w_chk_state),
        .o_hit       (w_hit)
    );

    // next-state of the detector for the beat on the input
    always_comb begin
        n_touch_x   = r_touch_x;
        n_touch_y   = r_touch_y;
        n_x_seen    = r_x_seen;
        n_y_seen    = r_y_seen;
        n_panel_off = r_panel_off;
        n_sweep     = r_sweep;
        w_res       = '0;
        case (i_opcode)
            tsgd_pkg::OP_PANEL_ON:  n_panel_off = 1'b0;
            tsgd_pkg::OP_PANEL_OFF: n_panel_off = 1'b1;
            tsgd_pkg::OP_X_POS, tsgd_pkg::OP_Y_POS,
            tsgd_pkg::OP_SLOT, tsgd_pkg::OP_TRACK_ID: begin
                if (w_enabled) begin
                    if (w_lift) begin
                        // finger lifted: stages drop, a new press is allowed
                        n_sweep = '{fwd: 2'b00, rev: 2'b00, armed: 1'b1};
                    end else begin
                        if (i_opcode == tsgd_pkg::OP_X_POS) begin
                            n_touch_x = w_coord;
                            n_x_seen  = 1'b1;
                        end
                        if (i_opcode == tsgd_pkg::OP_Y_POS) begin
                            n_touch_y = w_coord;
                            n_y_seen  = 1'b1;
                        end
                        if (w_pair) begin
                            n_x_seen  = 1'b0;
                            n_y_seen  = 1'b0;
                            n_sweep   = w_chk_state;
                            w_res     = '{press: w_hit, wake: w_hit & r_panel_off};
                        end
                    end
                end
            end
            default: ;  // other events carry nothing for us
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_en  <= 1'b0;
            r_sleep_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tsgd_pkg::REG_WAKE_EN:  r_wake_en  <= i_cfg_data;
                tsgd_pkg::REG_SLEEP_EN: r_sleep_en <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_x   <= '0;
            r_touch_y   <= '0;
            r_x_seen    <= 1'b0;
            r_y_seen    <= 1'b0;
            r_panel_off <= 1'b0;
            r_sweep     <= '{fwd: 2'b00, rev: 2'b00, armed: 1'b1};
        end else if (w_in_beat) begin
            r_touch_x   <= n_touch_x;
            r_touch_y   <= n_touch_y;
            r_x_seen    <= n_x_seen;
            r_y_seen    <= n_y_seen;
            r_panel_off <= n_panel_off;
            r_sweep     <= n_sweep;
        end
    end

    // output register with one skid slot; the skid only fills while the
    // output is held, and empties into the output as soon as it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_out_beat) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_in_beat) begin
                if (r_out_valid && i_stall) begin
                    r_skid_valid <= 1'b1;
                end
            end
            if (r_skid_valid) begin
                r_out_valid <= 1'b1;
            end else if (w_in_beat) begin
                r_out_valid <= 1'b1;
            end else if (w_out_beat) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_beat) begin
                r_out <= r_skid;
            end
        end else if (w_in_beat) begin
            if (r_out_valid && i_stall) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_stall         = r_skid_valid;
    assign o_valid         = r_out_valid;
    assign o_power_press   = r_out.press;
    assign o_press_is_wake = r_out.wake;

    // checks
    `TSGD_ASSERT_IMPL(a_skid_needs_out, r_skid_valid, r_out_valid)
    `TSGD_ASSERT_IMPL(a_hit_needs_arm, w_in_beat && w_res.press, r_sweep.armed)
    `TSGD_ASSERT_NEXT(a_press_disarms, w_in_beat && w_res.press, !r_sweep.armed)
    `TSGD_ASSERT_IMPL(a_wake_only_off, w_in_beat && w_res.wake, r_panel_off && w_res.press)

endmodule
